@@ hw/rtl/dtfd_pkg.sv @@
package dtfd_pkg;

  // Field widths
  localparam int ByteWidth  = 8;
  localparam int ValueWidth = 13;
  localparam int CountWidth = 10;

  // Payload limit before a frame is dropped
  localparam int MaxPayloadDefault = 512;

  // Digit offset
  localparam logic [ValueWidth-1:0] DigitZero = ValueWidth'(8'h30);

  // Closing event from the tracker to the value unit
  typedef struct packed {
    logic                 fire;
    logic                 ok;
    logic [ByteWidth-1:0] first_byte;
    logic [ByteWidth-1:0] second_byte;
  } close_t;

endpackage

@@ hw/rtl/dtfd_tracker.sv @@
module dtfd_tracker #(
  parameter int MAX_PAYLOAD = dtfd_pkg::MaxPayloadDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [dtfd_pkg::ByteWidth-1:0] rx_byte,
  output dtfd_pkg::close_t              close
);

  localparam logic HUNT  = 1'b0;
  localparam logic FRAME = 1'b1;

  localparam logic [2:0] HeadLen = 3'd5;
  localparam logic [1:0] TailLen = 2'd3;

  localparam logic [dtfd_pkg::CountWidth-1:0] OkCount  = dtfd_pkg::CountWidth'(4);
  localparam logic [dtfd_pkg::CountWidth-1:0] MaxCount =
    dtfd_pkg::CountWidth'(MAX_PAYLOAD);

  // Expected characters of the head and tail
  function automatic logic [7:0] head_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h73; // s
      3'd1:    c = 8'h74; // t
      3'd2:    c = 8'h61; // a
      3'd3:    c = 8'h72; // r
      3'd4:    c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tail_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h65; // e
      2'd1:    c = 8'h6e; // n
      2'd2:    c = 8'h64; // d
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  logic                              state, state_next;
  logic [2:0]                        head_progress, head_progress_next;
  logic [1:0]                        tail_progress, tail_progress_next;
  logic [dtfd_pkg::CountWidth-1:0]   payload_count, payload_count_next;
  logic [dtfd_pkg::ByteWidth-1:0]    first_byte, first_byte_next;
  logic [dtfd_pkg::ByteWidth-1:0]    second_byte, second_byte_next;
  logic [dtfd_pkg::CountWidth-1:0]   count_inc;

  // Next state for one received byte
  always_comb begin
    state_next         = state;
    head_progress_next = head_progress;
    tail_progress_next = tail_progress;
    payload_count_next = payload_count;
    first_byte_next    = first_byte;
    second_byte_next   = second_byte;
    count_inc          = payload_count + 1'b1;
    close.fire         = 1'b0;
    close.ok           = (payload_count == OkCount);
    close.first_byte   = first_byte;
    close.second_byte  = second_byte;

    if (state == HUNT) begin
      if (rx_byte == head_char(head_progress)) begin
        head_progress_next = head_progress + 1'b1;
      end else begin
        head_progress_next = (rx_byte == head_char(3'd0)) ? 3'd1 : 3'd0;
      end
      if (head_progress_next == HeadLen) begin
        state_next         = FRAME;
        head_progress_next = '0;
        tail_progress_next = '0;
        payload_count_next = '0;
      end
    end else begin
      // keep the first two payload bytes
      if (payload_count == '0) begin
        first_byte_next = rx_byte;
      end
      if (payload_count == dtfd_pkg::CountWidth'(1)) begin
        second_byte_next = rx_byte;
      end

      if (rx_byte == tail_char(tail_progress)) begin
        tail_progress_next = tail_progress + 1'b1;
      end else begin
        tail_progress_next = (rx_byte == tail_char(2'd0)) ? 2'd1 : 2'd0;
      end

      if (tail_progress_next == TailLen) begin
        close.fire         = 1'b1;
        state_next         = HUNT;
        head_progress_next = '0;
        tail_progress_next = '0;
        payload_count_next = '0;
      end else if (count_inc >= MaxCount) begin
        // overflow: drop the frame
        state_next         = HUNT;
        head_progress_next = '0;
        tail_progress_next = '0;
        payload_count_next = '0;
      end else begin
        payload_count_next = count_inc;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= HUNT;
      head_progress <= '0;
      tail_progress <= '0;
      payload_count <= '0;
    end else if (accept) begin
      state         <= state_next;
      head_progress <= head_progress_next;
      tail_progress <= tail_progress_next;
      payload_count <= payload_count_next;
    end
  end

  // Captured payload bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      first_byte  <= first_byte_next;
      second_byte <= second_byte_next;
    end
  end

endmodule

@@ hw/rtl/dtfd_value.sv @@
module dtfd_value (
  input  dtfd_pkg::close_t                       close,
  output logic signed [dtfd_pkg::ValueWidth-1:0] value
);

  logic [dtfd_pkg::ValueWidth-1:0] tens;
  logic [dtfd_pkg::ValueWidth-1:0] units;
  logic [dtfd_pkg::ValueWidth-1:0] sum;

  // (b0 - '0') * 10 + (b1 - '0'), wrapping, no digit check
  always_comb begin
    tens  = dtfd_pkg::ValueWidth'(close.first_byte) - dtfd_pkg::DigitZero;
    units = dtfd_pkg::ValueWidth'(close.second_byte) - dtfd_pkg::DigitZero;
    sum   = (tens << 3) + (tens << 1) + units;
    value = close.ok ? $signed(sum) : '1;
  end

endmodule

@@ hw/rtl/delimited_two_digit_frame_decoder.sv @@
// Channel  | Signals                                  | Direction
// rx       | rx_valid, rx_ready, rx_byte              | in
// frame    | frame_valid, frame_ready, frame_ok,      | out
//          | frame_value                              |
//
// One byte is taken per cycle while rx_ready is high; a closing 'd' shows its result in the next cycle.
// The matcher and value arithmetic sit between the state and the result register.
// rx_ready drops only while a held result waits and frame_ready is low.
// Reset (rst, synchronous) returns to hunting for the head and empties the output.
module delimited_two_digit_frame_decoder #(
  parameter int MAX_PAYLOAD = dtfd_pkg::MaxPayloadDefault
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   rx_valid,
  output logic                                   rx_ready,
  input  logic [dtfd_pkg::ByteWidth-1:0]         rx_byte,
  output logic                                   frame_valid,
  input  logic                                   frame_ready,
  output logic                                   frame_ok,
  output logic signed [dtfd_pkg::ValueWidth-1:0] frame_value
);

  dtfd_pkg::close_t                       close;
  logic signed [dtfd_pkg::ValueWidth-1:0] value;
  logic                                   accept;

  // Request taken when the result slot is free or draining
  assign rx_ready = !frame_valid || frame_ready;
  assign accept   = rx_valid && rx_ready;

  dtfd_tracker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_tracker (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .close   (close)
  );

  dtfd_value u_value (
    .close (close),
    .value (value)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (accept && close.fire) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && close.fire) begin
      frame_ok    <= close.ok;
      frame_value <= value;
    end
  end

endmodule

@@ sim/testbench.sv @@
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PayloadLimit = dtfd_pkg::MaxPayloadDefault;
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 8;

  typedef struct {
    logic                                   ok;
    logic signed [dtfd_pkg::ValueWidth-1:0] value;
  } frame_t;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   rx_valid = 1'b0;
  logic                                   rx_ready;
  logic [dtfd_pkg::ByteWidth-1:0]         rx_byte = '0;
  logic                                   frame_valid;
  logic                                   frame_ready = 1'b0;
  logic                                   frame_ok;
  logic signed [dtfd_pkg::ValueWidth-1:0] frame_value;

  // bytes still to send, decoded frames still to arrive
  logic [dtfd_pkg::ByteWidth-1:0] rx_pending [$];
  frame_t                         frames_due [$];

  // decoder state as seen from outside
  string                           head_text = "start";
  string                           tail_text = "end";
  logic                            in_frame;
  int                              head_idx;
  int                              tail_idx;
  logic [dtfd_pkg::CountWidth-1:0] payload_cnt;
  logic [dtfd_pkg::ByteWidth-1:0]  first_b;
  logic [dtfd_pkg::ByteWidth-1:0]  second_b;

  int bytes_total;
  int bytes_taken = 0;
  int mismatches  = 0;
  int idle_cycles = 0;
  int send_gap    = 0;
  int send_quiet  = 0;
  int take_hold   = 0;
  int take_quiet  = 0;

  delimited_two_digit_frame_decoder #(
    .MAX_PAYLOAD(PayloadLimit)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .frame_ok   (frame_ok),
    .frame_value(frame_value)
  );

  always #10 clk = ~clk;

  // random wait between requests, with occasional runs of back-to-back requests
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) quiet = $urandom_range(20, 80);
    return $urandom_range(0, 5);
  endfunction

  // frame decoder: one byte in, at most one decoded frame out
  function automatic void decode_byte(input logic [dtfd_pkg::ByteWidth-1:0] b);
    frame_t      res;
    logic [31:0] sum;
    if (!in_frame) begin
      if (head_idx < 5 && b == head_text[head_idx]) head_idx++;
      else head_idx = (b == head_text[0]) ? 1 : 0;
      if (head_idx >= 5) begin
        in_frame    = 1'b1;
        head_idx    = 0;
        tail_idx    = 0;
        payload_cnt = '0;
      end
      return;
    end
    if (payload_cnt == 0) first_b = b;
    else if (payload_cnt == 1) second_b = b;
    if (tail_idx < 3 && b == tail_text[tail_idx]) tail_idx++;
    else tail_idx = (b == tail_text[0]) ? 1 : 0;
    if (tail_idx >= 3) begin
      // payload of two bytes plus "en" before the closing 'd'
      res.ok = (payload_cnt == 4);
      if (res.ok) begin
        sum = (32'(first_b) - 32'd48) * 32'd10 + (32'(second_b) - 32'd48);
        res.value = sum[dtfd_pkg::ValueWidth-1:0];
      end else begin
        res.value = '1;
      end
      frames_due.push_back(res);
      in_frame = 1'b0;
      head_idx = 0;
      tail_idx = 0;
      payload_cnt = '0;
      return;
    end
    payload_cnt = payload_cnt + 1'b1;
    // overflow: frame dropped, this byte does not start a head
    if (payload_cnt >= PayloadLimit) begin
      in_frame = 1'b0;
      head_idx = 0;
      tail_idx = 0;
      payload_cnt = '0;
    end
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_pending.push_back(s[i]);
  endtask

  function automatic logic [dtfd_pkg::ByteWidth-1:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [dtfd_pkg::ByteWidth-1:0] any_digit();
    if ($urandom_range(0, 3) == 0) return any_byte();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [dtfd_pkg::ByteWidth-1:0] not_tail_start();
    logic [dtfd_pkg::ByteWidth-1:0] b;
    b = any_byte();
    if (b == tail_text[0]) b = 8'h00;
    return b;
  endfunction

  // payload of fill bytes then "end" if closed, closing at payload count n+2
  task automatic add_long_frame(input int n, input logic closed);
    add_text("start");
    for (int i = 0; i < n; i++) rx_pending.push_back(not_tail_start());
    if (closed) add_text("end");
  endtask

  // stimulus
  initial begin
    int  kind;
    int  len;
    logic long_done;
    logic near_done;
    long_done = 1'b0;
    near_done = 1'b0;
    in_frame    = 1'b0;
    head_idx    = 0;
    tail_idx    = 0;
    payload_cnt = '0;
    first_b     = '0;
    second_b    = '0;

    // directed: restarted head with extreme bytes, empty payload, tail mismatch
    add_text("sstart");
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(8'h00);
    add_text("end");
    add_text("startend");
    add_text("starteend");
    add_text("stastart09end");

    while (rx_pending.size() < 1300) begin
      kind = $urandom_range(0, 99);
      if (!long_done && rx_pending.size() > 400) begin
        // overflow, then the rest of a head that must not match
        add_long_frame(PayloadLimit, 1'b0);
        add_text("tart");
        add_text("start37end");
        long_done = 1'b1;
      end else if (!near_done && rx_pending.size() > 800) begin
        // closing 'd' on the last byte before the limit
        add_long_frame(PayloadLimit - 3, 1'b1);
        near_done = 1'b1;
      end else if (kind < 60) begin
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) rx_pending.push_back(any_byte());
        add_text("start");
        rx_pending.push_back(any_digit());
        rx_pending.push_back(any_digit());
        add_text("end");
      end else if (kind < 75) begin
        add_text("start");
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) rx_pending.push_back(any_digit());
        add_text("end");
      end else if (kind < 85) begin
        // head prefix followed by a random byte
        add_text(head_text.substr(0, $urandom_range(0, 3)));
        rx_pending.push_back(any_byte());
        if ($urandom_range(0, 1) == 1) add_text("12end");
      end else if (kind < 95) begin
        // broken tail inside the payload
        add_text("start");
        rx_pending.push_back(any_digit());
        add_text(tail_text.substr(0, $urandom_range(0, 1)));
        rx_pending.push_back(any_digit());
        add_text("end");
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) rx_pending.push_back(any_byte());
      end
    end
    bytes_total = rx_pending.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < bytes_total) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // rx driver: predicts each accepted byte, then offers the next request
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
      send_gap = draw_wait(send_quiet);
    end else begin
      if (rx_valid && rx_ready) begin
        decode_byte(rx_byte);
        bytes_taken++;
      end
      if (!rx_valid || rx_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          rx_valid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          rx_valid <= 1'b1;
          rx_byte  <= rx_pending.pop_front();
          send_gap = draw_wait(send_quiet);
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // frame monitor with random back-pressure
  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      take_hold = draw_wait(take_quiet);
    end else begin
      if (frame_valid && frame_ready) begin
        if (frames_due.size() == 0) begin
          $error("unexpected frame: ok %0b value %0d", frame_ok, frame_value);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          if (frame_ok !== want.ok) begin
            $error("frame_ok: expected %0b, got %0b", want.ok, frame_ok);
            mismatches++;
          end
          if (frame_value !== want.value) begin
            $error("frame_value: expected %0d, got %0d", want.value, frame_value);
            mismatches++;
          end
        end
        take_hold = draw_wait(take_quiet);
      end else if (take_hold > 0) begin
        take_hold--;
      end
    end
    frame_ready <= !rst && (take_hold == 0);
  end

  // watchdog on cycles with no accepted request on either side
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (frame_valid && frame_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

@@ delimited_two_digit_frame_decoder.f @@
hw/rtl/dtfd_pkg.sv
hw/rtl/dtfd_tracker.sv
hw/rtl/dtfd_value.sv
hw/rtl/delimited_two_digit_frame_decoder.sv
sim/testbench.sv
